// ===== sv/tmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants of the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  // control characters interpreted by a put action
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // tab and vertical tab repeat their basic action this many times
  localparam int unsigned REPEAT_COUNT = 4;

  // action codes carried in the input tuser
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SWEEP,
    ST_RDATA,
    ST_RESP
  } state_t;

  // commands from the sequencer to the screen store
  typedef struct packed {
    logic rd;      // read the addressed cell
    logic wr;      // write the addressed cell
    logic scroll;  // rotate the top row, invalidating the new bottom row
    logic mark;    // mark the addressed row as holding real data
  } store_cmd_t;

endpackage

// ===== sv/text_mode_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer
// Teletype console over a character-cell screen with a linear cursor.
// ----------------------------------------------------------------------------
// Flow: one item at a time; a new item is taken only after the last result has
//   been loaded into the output register. The first write into a blank row
//   sweeps that row to zero through the single memory port, and a character
//   printed past the end scrolls the screen first.
// Reset: cursor to cell zero, all rows marked blank (read as zero); no sweep.
// ----------------------------------------------------------------------------
module text_mode_console_writer
  import tmcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // character[7:0], color[15:8], read_row[20:16],
                                  // read_column[27:21], zero[31:28]
  input  logic [0:0]  in_tuser,   // action[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // cell_char[7:0], cell_color[15:8],
                                  // cursor_line[20:16], cursor_column[27:21],
                                  // zero[31:28]
);

  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned LINE_W = $clog2(ROWS + 1);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned REP_W  = $clog2(REPEAT_COUNT);

  state_t state_r, state_nxt;

  logic              act_r;
  logic [7:0]        char_r;
  logic [7:0]        color_r;
  logic [4:0]        rrow_r;
  logic [6:0]        rcol_r;

  logic [LINE_W-1:0] line_r, line_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt;
  logic [COL_W-1:0]  sweep_r, sweep_nxt;
  logic [15:0]       res_cell_r, res_cell_nxt;

  logic              out_valid_r;
  logic [31:0]       out_data_r;

  store_cmd_t        cmd;
  logic [ROW_W-1:0]  st_row;
  logic [COL_W-1:0]  st_col;
  logic [15:0]       st_wdata;
  logic              row_ok;
  logic [15:0]       rdata;

  logic              in_accept;
  logic              out_free;
  logic              is_tab;
  logic              is_feed;
  logic              is_write;
  logic              rd_in_range;
  logic              at_end;
  logic              last_sweep;
  logic [15:0]       put_cell;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign is_tab      = (char_r == CH_TAB);
  assign is_feed     = (char_r == CH_LF) || (char_r == CH_VT);
  assign is_write    = (char_r != CH_BS) && (char_r != CH_CR) && !is_feed;
  assign rd_in_range = (32'(rrow_r) < ROWS) && (32'(rcol_r) < COLUMNS);
  assign at_end      = (line_r == LINE_W'(ROWS));
  assign last_sweep  = (sweep_r == COL_W'(COLUMNS - 1));
  assign put_cell    = {color_r, (is_tab ? CH_SPACE : char_r)};

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (act_r == ACT_READ) begin
          state_nxt = rd_in_range ? ST_RDATA : ST_RESP;
        end else if (is_write) begin
          if (at_end) begin
            state_nxt = ST_STEP;
          end else if (!row_ok) begin
            state_nxt = ST_SWEEP;
          end else if (is_tab && rep_r != '0) begin
            state_nxt = ST_STEP;
          end else begin
            state_nxt = ST_RESP;
          end
        end else if (is_feed && rep_r != '0) begin
          state_nxt = ST_STEP;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_SWEEP: begin
        if (last_sweep) begin
          state_nxt = (is_tab && rep_r != '0) ? ST_STEP : ST_RESP;
        end
      end
      ST_RDATA: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------- datapath / commands
  always_comb begin
    cmd          = '0;
    line_nxt     = line_r;
    col_nxt      = col_r;
    rep_nxt      = rep_r;
    sweep_nxt    = sweep_r;
    res_cell_nxt = res_cell_r;
    st_row       = (act_r == ACT_READ) ? ROW_W'(rrow_r) : ROW_W'(line_r);
    st_col       = (act_r == ACT_READ) ? COL_W'(rcol_r) : col_r;
    st_wdata     = put_cell;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          rep_nxt   = ((in_tdata[7:0] == CH_TAB) || (in_tdata[7:0] == CH_VT)) ?
                      REP_W'(REPEAT_COUNT - 1) : '0;
          sweep_nxt = '0;
        end
      end
      ST_STEP: begin
        res_cell_nxt = '0;
        if (act_r == ACT_READ) begin
          cmd.rd = rd_in_range;
        end else if (is_write) begin
          if (at_end) begin
            // past the last cell: scroll and pull the cursor back one row
            cmd.scroll = 1'b1;
            line_nxt   = LINE_W'(ROWS - 1);
          end else if (row_ok) begin
            cmd.wr = 1'b1;
            if (col_r == COL_W'(COLUMNS - 1)) begin
              col_nxt  = '0;
              line_nxt = line_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
            if (is_tab && rep_r != '0) rep_nxt = rep_r - 1'b1;
          end else begin
            sweep_nxt = '0;
          end
        end else if (is_feed) begin
          if (line_r < LINE_W'(ROWS - 1)) begin
            line_nxt = line_r + 1'b1;
          end else begin
            cmd.scroll = 1'b1;
          end
          if (rep_r != '0) rep_nxt = rep_r - 1'b1;
        end else if (char_r == CH_CR) begin
          if (!at_end) col_nxt = '0;
        end else begin
          // backspace, stopping at cell zero
          if (col_r != '0) begin
            col_nxt = col_r - 1'b1;
          end else if (line_r != '0) begin
            line_nxt = line_r - 1'b1;
            col_nxt  = COL_W'(COLUMNS - 1);
          end
        end
      end
      ST_SWEEP: begin
        // blank row: clear every cell, dropping the new character in place
        cmd.wr   = 1'b1;
        st_col   = sweep_r;
        st_wdata = (sweep_r == col_r) ? put_cell : 16'd0;
        if (last_sweep) begin
          cmd.mark  = 1'b1;
          sweep_nxt = '0;
          if (col_r == COL_W'(COLUMNS - 1)) begin
            col_nxt  = '0;
            line_nxt = line_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
          if (is_tab && rep_r != '0) rep_nxt = rep_r - 1'b1;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      ST_RDATA: begin
        res_cell_nxt = rdata;
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      line_r      <= '0;
      col_r       <= '0;
      rep_r       <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      rep_r   <= rep_nxt;
      sweep_r <= sweep_nxt;
      if (state_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_cell_r <= res_cell_nxt;
    if (in_accept) begin
      act_r   <= in_tuser[0];
      char_r  <= in_tdata[7:0];
      color_r <= in_tdata[15:8];
      rrow_r  <= in_tdata[20:16];
      rcol_r  <= in_tdata[27:21];
    end
    if (state_r == ST_RESP && out_free) begin
      out_data_r <= {4'd0, 7'(col_r), 5'(line_r), res_cell_r[15:8], res_cell_r[7:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  tmcw_screen_store #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .row    (st_row),
    .col    (st_col),
    .wdata  (st_wdata),
    .row_ok (row_ok),
    .rdata  (rdata)
  );

endmodule

// ===== sv/tmcw_screen_store.sv =====
// ----------------------------------------------------------------------------
// tmcw_screen_store
// Cell memory with a rotating top row and one valid bit per physical row.
// Scrolling moves the top pointer; a row that is not valid reads as zero.
// ----------------------------------------------------------------------------
module tmcw_screen_store
  import tmcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  store_cmd_t                  cmd,
  input  logic [$clog2(ROWS)-1:0]     row,      // logical row, below ROWS
  input  logic [$clog2(COLUMNS)-1:0]  col,
  input  logic [15:0]                 wdata,
  output logic                        row_ok,   // addressed row holds data
  output logic [15:0]                 rdata     // valid in the cycle after cmd.rd
);

  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned CELLS  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  logic [15:0]      mem [CELLS];
  logic [15:0]      mem_q_r;
  logic             q_ok_r;
  logic [ROWS-1:0]  row_valid_r;
  logic [ROW_W-1:0] top_r;

  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  phys_row;
  logic [ADDR_W-1:0] addr;

  // logical row to physical row, then to a linear cell address
  always_comb begin
    row_sum  = {1'b0, row} + {1'b0, top_r};
    if (row_sum >= (ROW_W+1)'(ROWS)) begin
      phys_row = ROW_W'(row_sum - (ROW_W+1)'(ROWS));
    end else begin
      phys_row = ROW_W'(row_sum);
    end
    addr   = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    row_ok = row_valid_r[phys_row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      top_r       <= '0;
    end else begin
      if (cmd.scroll) begin
        row_valid_r[top_r] <= 1'b0;
        top_r <= (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
      end else if (cmd.mark) begin
        row_valid_r[phys_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      mem_q_r <= mem[addr];
      q_ok_r  <= row_valid_r[phys_row];
    end
  end

  assign rdata = q_ok_r ? mem_q_r : 16'd0;

endmodule

// ===== test/text_mode_console_writer_test.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer_test
// Self-checking bench for the teletype console writer. A queue of put and
// read items is streamed into the block with random gaps; every result is
// checked against a behavioural copy of the screen and cursor kept here.
// ----------------------------------------------------------------------------
module text_mode_console_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tmcw_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_AT      = 150;  // result count at which the long stall starts
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic       action;
    logic [7:0] ch;
    logic [7:0] colour;
    logic [4:0] row;
    logic [6:0] col;
  } console_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] colour;
    logic [4:0] line;
    logic [6:0] column;
  } console_view_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // character[7:0], color[15:8], read_row[20:16],
                                 // read_column[27:21], zero[31:28]
  logic [0:0]  in_tuser   = '0;  // action[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // cell_char[7:0], cell_color[15:8],
                                 // cursor_line[20:16], cursor_column[27:21],
                                 // zero[31:28]

  text_mode_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  console_item_t items_to_send[$];
  console_view_t expected_views[$];

  // shadow of the screen store and cursor
  logic [15:0] screen [0:CELLS-1];
  int unsigned cursor;

  int errors       = 0;
  int results_seen = 0;
  int puts_done    = 0;
  int reads_done   = 0;
  int scrolls      = 0;
  int past_end     = 0;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   send_wait = 0;
  int   send_calm = 0;
  int   recv_wait = 0;
  int   recv_calm = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // behavioural screen
  // --------------------------------------------------------------------------
  function void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '0;
    scrolls++;
  endfunction

  function void feed_line();
    if (cursor + COLUMNS < CELLS) cursor += COLUMNS;
    else scroll_screen();
  endfunction

  function void write_glyph(logic [7:0] ch, logic [7:0] colour);
    // past the last cell: make room on the bottom row first
    if (cursor >= CELLS) begin
      cursor -= COLUMNS;
      scroll_screen();
    end
    screen[cursor] = {colour, ch};
    cursor++;
  endfunction

  function console_view_t console_step(console_item_t it);
    console_view_t v;
    v = '0;
    if (it.action == ACT_PUT) begin
      puts_done++;
      case (it.ch)
        CH_TAB:  repeat (REPEAT_COUNT) write_glyph(CH_SPACE, it.colour);
        CH_VT:   repeat (REPEAT_COUNT) feed_line();
        CH_CR:   if (cursor / COLUMNS < ROWS) cursor = (cursor / COLUMNS) * COLUMNS;
        CH_LF:   feed_line();
        CH_BS:   if (cursor >= 1) cursor--;
        default: write_glyph(it.ch, it.colour);
      endcase
    end else begin
      reads_done++;
      if (it.row < ROWS && it.col < COLUMNS) {v.colour, v.ch} = screen[it.row * COLUMNS + it.col];
    end
    v.line   = 5'((cursor / COLUMNS) & 31);
    v.column = 7'(cursor % COLUMNS);
    if (cursor == CELLS) past_end++;
    return v;
  endfunction

  function void check_field(string what, int exp_val, int got_val);
    if (exp_val != got_val) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_val, got_val);
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus builders
  // --------------------------------------------------------------------------
  task automatic queue_put(logic [7:0] ch, logic [7:0] colour);
    console_item_t it;
    it.action = ACT_PUT;
    it.ch     = ch;
    it.colour = colour;
    it.row    = 5'($urandom);
    it.col    = 7'($urandom);
    items_to_send.push_back(it);
  endtask

  task automatic queue_read(logic [4:0] row, logic [6:0] col);
    console_item_t it;
    it.action = ACT_READ;
    it.ch     = 8'($urandom);
    it.colour = 8'($urandom);
    it.row    = row;
    it.col    = col;
    items_to_send.push_back(it);
  endtask

  task automatic queue_glyph();
    logic [7:0] c;
    c = 8'($urandom);
    if (c == CH_BS || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_CR) c = c + 8'h40;
    queue_put(c, 8'($urandom));
  endtask

  // mostly inside the screen, now and then anywhere the fields reach
  task automatic queue_random_read();
    if ($urandom_range(0, 99) < 85)
      queue_read(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
    else
      queue_read(5'($urandom), 7'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // stimulus and run control
  // --------------------------------------------------------------------------
  initial begin
    int target;
    int n;
    int items_total;
    console_item_t it;

    for (int i = 0; i < CELLS; i++) screen[i] = '0;
    cursor = 0;

    // directed: control codes, field extremes, out-of-range reads
    queue_put(CH_BS, 8'h00);            // backspace at cell zero
    queue_read(5'd0, 7'd0);
    queue_put(8'h41, 8'hFF);
    queue_put(8'hFF, 8'h00);
    queue_put(8'h00, 8'hA5);
    queue_put(CH_TAB, 8'h5A);
    queue_put(CH_BS, 8'h00);
    queue_read(5'd0, 7'd1);
    queue_read(5'd0, 7'd6);
    queue_put(CH_CR, 8'h00);
    queue_put(CH_LF, 8'h00);
    queue_put(CH_VT, 8'h00);
    queue_read(5'd24, 7'd79);
    queue_read(5'd31, 7'd127);
    queue_read(5'd25, 7'd0);
    queue_read(5'd0, 7'd80);
    repeat (5) queue_put(CH_VT, 8'h00); // down to the bottom row and beyond
    queue_put(CH_LF, 8'h00);            // line feed on the last row
    queue_put(8'h7E, 8'h3C);
    queue_read(5'd24, 7'd0);
    queue_read(5'd23, 7'd0);

    // random: text runs long enough to run off the end of the screen
    target = items_to_send.size() + RANDOM_ITEMS;
    while (items_to_send.size() < target) begin
      n = $urandom_range(0, 99);
      if (n < 45) begin
        repeat ($urandom_range(1, 40)) begin
          if ($urandom_range(0, 5) == 0) queue_put(CH_TAB, 8'($urandom));
          else queue_glyph();
        end
      end else if (n < 60) begin
        case ($urandom_range(0, 3))
          0: begin
            queue_put(CH_CR, 8'($urandom));
            queue_put(CH_LF, 8'($urandom));
          end
          1: queue_put(CH_LF, 8'($urandom));
          2: queue_put(CH_CR, 8'($urandom));
          default: queue_put(CH_VT, 8'($urandom));
        endcase
      end else if (n < 68) begin
        repeat ($urandom_range(1, 3)) queue_put(CH_BS, 8'($urandom));
      end else if (n < 88) begin
        repeat ($urandom_range(1, 4)) queue_random_read();
      end else begin
        repeat ($urandom_range(1, 3)) begin
          it = console_item_t'({$urandom, $urandom});
          items_to_send.push_back(it);
        end
      end
    end
    items_total = items_to_send.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every item gives exactly one result
    while (results_seen < items_total)
      @(negedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d puts and %0d reads, %0d scrolls, cursor past the end %0d times",
             puts_done, reads_done, scrolls, past_end);
    if (errors == 0) begin
      $display("text_mode_console_writer_test: PASS");
    end else begin
      $display("text_mode_console_writer_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d items unsent and %0d results outstanding",
             items_to_send.size(), expected_views.size());
    $display("text_mode_console_writer_test: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  console_item_t next_item;

  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (in_taken) begin
        if (send_calm > 0) begin
          send_calm--;
          send_wait = 0;
        end else begin
          if ($urandom_range(0, 49) == 0) send_calm = 30;
          send_wait = $urandom_range(0, 9);
        end
      end
      if (send_wait > 0) begin
        send_wait--;
        in_tvalid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        next_item = items_to_send.pop_front();
        in_tdata  <= {4'b0, next_item.col, next_item.row, next_item.colour, next_item.ch};
        in_tuser  <= next_item.action;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: per-item stall, plus one long hold to back up the input
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if (results_seen == HOLD_AT) begin
          recv_wait = HOLD_CYCLES;
        end else if (recv_calm > 0) begin
          recv_calm--;
          recv_wait = 0;
        end else begin
          if ($urandom_range(0, 49) == 0) recv_calm = 30;
          recv_wait = $urandom_range(0, 9);
        end
      end
      if (recv_wait > 0) begin
        out_tready <= 1'b0;
        if (out_tvalid) recv_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // accept items, predict, check results
  // --------------------------------------------------------------------------
  console_item_t seen_item;
  console_view_t want, got;

  always @(posedge clk) begin
    in_taken  <= rst_n && in_tvalid && in_tready;
    out_taken <= rst_n && out_tvalid && out_tready;

    if (rst_n && in_tvalid && in_tready) begin
      seen_item.action = in_tuser[0];
      seen_item.ch     = in_tdata[7:0];
      seen_item.colour = in_tdata[15:8];
      seen_item.row    = in_tdata[20:16];
      seen_item.col    = in_tdata[27:21];
      expected_views.push_back(console_step(seen_item));
    end

    if (rst_n && out_tvalid && out_tready) begin
      got.ch     = out_tdata[7:0];
      got.colour = out_tdata[15:8];
      got.line   = out_tdata[20:16];
      got.column = out_tdata[27:21];
      results_seen++;
      if (expected_views.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got 0x%08h", $time, out_tdata);
      end else begin
        want = expected_views.pop_front();
        check_field("cell_char", want.ch, got.ch);
        check_field("cell_color", want.colour, got.colour);
        check_field("cursor_line", want.line, got.line);
        check_field("cursor_column", want.column, got.column);
      end
    end
  end

endmodule
